>>> rtl/rtsc_pkg.sv
package rtsc_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_TWO_WAY_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_SUBMODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_VOLTAGE_FWD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_VOLTAGE_REV  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_FWD         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_REV         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REGULATION_RANGE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT       = 3'd7;

    // Reverse flow submodes
    localparam logic [1:0] REV_INVERT = 2'd0;
    localparam logic [1:0] REV_BYPASS = 2'd1;
    localparam logic [1:0] REV_FIXED  = 2'd2;

    // Reverse flow threshold in watts
    localparam logic signed [31:0] REV_POWER_LIMIT = -32'sd100;

    // Clamp limit: least of step_count, MAX_STEPS and 63
    localparam int         MAX_STEPS = 32;
    localparam logic [5:0] LIM_CAP   = (MAX_STEPS > 63) ? 6'd63 : 6'(MAX_STEPS);

    // 0.0001 bias on the step distance, applied as a scale of 10000
    localparam logic [13:0] ROUND_SCALE = 14'd10000;

    // Ratio limits, Q16
    localparam logic [16:0] RATIO_ONE = 17'd65536;
    localparam logic [16:0] RATIO_MAX = 17'd131071;

    // Serial divider
    localparam int DIV_NUM_W   = 40;
    localparam int DIV_DEN_W   = 47;
    localparam int DIV_Q_W     = 18;
    localparam int DIV_CNT_W   = 5;
    localparam int MOVE_QBITS  = 7;
    localparam int RATIO_QBITS = 17;

    typedef struct packed {
        logic        two_way_mode;
        logic [1:0]  reverse_submode;
        logic [16:0] ref_voltage_fwd;
        logic [16:0] ref_voltage_rev;
        logic [14:0] band_fwd;
        logic [14:0] band_rev;
        logic [14:0] regulation_range;
        logic [5:0]  step_count;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic mul1;
        logic mul2;
        logic div_move;
        logic take_move;
        logic take_old;
        logic take_new;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_stat_t;

    // 1 +/- quotient, saturated to 0..131071; top quotient bit flags overflow
    function automatic logic [16:0] ratio_of(input logic [DIV_Q_W-1:0] q,
                                             input logic neg,
                                             input logic special);
        logic [16:0] qv;
        logic        sat;
        logic [16:0] res;
        qv  = q[RATIO_QBITS-1:0];
        sat = q[RATIO_QBITS];
        if (special) begin
            res = RATIO_ONE;
        end else if (neg) begin
            res = (sat || qv > RATIO_ONE) ? 17'd0 : RATIO_ONE - qv;
        end else begin
            res = (sat || qv > RATIO_ONE - 17'd1) ? RATIO_MAX : RATIO_ONE + qv;
        end
        return res;
    endfunction

endpackage

>>> rtl/rtsc_cfg.sv
module rtsc_cfg
    import rtsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TWO_WAY_MODE:     cfg_next.two_way_mode     = cfg_wdata[0];
                CFG_REVERSE_SUBMODE:  cfg_next.reverse_submode  = cfg_wdata[1:0];
                CFG_REF_VOLTAGE_FWD:  cfg_next.ref_voltage_fwd  = cfg_wdata[16:0];
                CFG_REF_VOLTAGE_REV:  cfg_next.ref_voltage_rev  = cfg_wdata[16:0];
                CFG_BAND_FWD:         cfg_next.band_fwd         = cfg_wdata[14:0];
                CFG_BAND_REV:         cfg_next.band_rev         = cfg_wdata[14:0];
                CFG_REGULATION_RANGE: cfg_next.regulation_range = cfg_wdata[14:0];
                CFG_STEP_COUNT:       cfg_next.step_count       = cfg_wdata[5:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.two_way_mode     <= 1'b0;
            cfg_reg.reverse_submode  <= REV_INVERT;
            cfg_reg.ref_voltage_fwd  <= RATIO_ONE;
            cfg_reg.ref_voltage_rev  <= RATIO_ONE;
            cfg_reg.band_fwd         <= 15'd0;
            cfg_reg.band_rev         <= 15'd0;
            cfg_reg.regulation_range <= 15'd6554;
            cfg_reg.step_count       <= 6'd16;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/rtsc_div.sv
module rtsc_div
    import rtsc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] dividend,
    input  logic [DIV_DEN_W-1:0] divisor,
    input  logic [DIV_CNT_W-1:0] steps,
    output logic [DIV_Q_W-1:0]   quotient,
    output logic                 done
);

    // Restoring division, one quotient bit per cycle; the divisor arrives
    // pre-shifted so that the first bit taken flags quotient overflow.
    logic [DIV_NUM_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] dsh_reg, dsh_next;
    logic [DIV_Q_W-1:0]   q_reg, q_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 ge;

    assign ge = {{(DIV_DEN_W-DIV_NUM_W){1'b0}}, rem_reg} >= dsh_reg;

    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend;
            dsh_next  = divisor;
            q_next    = '0;
            cnt_next  = steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = rem_reg - dsh_reg[DIV_NUM_W-1:0];
            end
            q_next   = {q_reg[DIV_Q_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

>>> rtl/rtsc_dp.sv
module rtsc_dp
    import rtsc_pkg::*;
#(
    parameter int NUM_TAPS = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic               s_tap_index,
    input  logic [16:0]        s_measured_voltage,
    input  logic signed [31:0] s_active_power_w,
    output logic signed [6:0]  m_tap_step,
    output logic [16:0]        m_tap_ratio,
    output logic               m_flow_reverse,
    output logic               m_tap_changed
);

    // Input item
    logic               tap_reg;
    logic [16:0]        v_reg;
    logic signed [31:0] p_reg;

    // Step store, one register per tap
    logic signed [6:0] store_reg [NUM_TAPS];
    logic signed [6:0] old_sel;

    // Prep stage
    logic               rev_c, bypass_c, hold_c, inv_c;
    logic [16:0]        ref_c;
    logic [14:0]        band_c;
    logic signed [19:0] diff1_c, diff2_c, band_s, d2_c;
    logic [18:0]        diff2_abs, d2_abs;

    logic              rev_reg, bypass_reg, hold_reg;
    logic [18:0]       d2mag_reg;
    logic              d2neg_reg, d2zero_reg;
    logic signed [6:0] old_reg;

    // Multiplier stages
    logic [24:0] num_reg;
    logic [39:0] numx_reg;
    logic [29:0] denx_reg;

    // Divider operands and result
    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_dividend;
    logic [DIV_DEN_W-1:0] div_divisor;
    logic [DIV_CNT_W-1:0] div_steps;
    logic [DIV_Q_W-1:0]   div_q;

    logic signed [6:0] ratio_step;
    logic [5:0]        rs_abs;
    logic [20:0]       rmag;
    logic [22:0]       rdividend;
    logic              special;

    // Step update
    logic [7:0]         mv_mag, mv_sel;
    logic signed [9:0]  mv_s, sum_c, clamp_c, lim_s;
    logic [5:0]         lim;
    logic signed [6:0]  step_c;
    logic signed [6:0]  step_new_reg;
    logic [16:0]        ratio_old_reg, ratio_new_reg;

    // Output register
    logic signed [6:0] out_step_reg;
    logic [16:0]       out_ratio_reg;
    logic              out_rev_reg, out_chg_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            tap_reg <= s_tap_index;
            v_reg   <= s_measured_voltage;
            p_reg   <= s_active_power_w;
        end
    end

    // A tap outside the store reads as neutral and is never written
    always_comb begin
        old_sel = '0;
        for (int i = 0; i < NUM_TAPS; i++) begin
            if (tap_reg == 1'(i)) begin
                old_sel = store_reg[i];
            end
        end
    end

    for (genvar g = 0; g < NUM_TAPS; g++) begin : g_store
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                store_reg[g] <= '0;
            end else if (cmd.take_new && tap_reg == 1'(g)) begin
                store_reg[g] <= step_new_reg;
            end
        end
    end

    always_comb begin
        rev_c    = cfg.two_way_mode && (p_reg <= REV_POWER_LIMIT);
        bypass_c = rev_c && (cfg.reverse_submode == REV_BYPASS);
        inv_c    = rev_c && (cfg.reverse_submode != REV_FIXED);
        ref_c    = rev_c ? cfg.ref_voltage_rev : cfg.ref_voltage_fwd;
        band_c   = rev_c ? cfg.band_rev : cfg.band_fwd;
        band_s   = signed'({5'b0, band_c});
        diff1_c  = signed'({3'b0, ref_c}) - signed'({3'b0, v_reg});
        diff2_c  = {diff1_c[18:0], 1'b0};
        diff2_abs = diff2_c[19] ? 19'(-diff2_c) : diff2_c[18:0];
        hold_c   = diff2_abs < {4'b0, band_c};
        // Distance to the near band edge
        d2_c     = (v_reg < ref_c) ? diff2_c - band_s : diff2_c + band_s;
        d2_abs   = d2_c[19] ? 19'(-d2_c) : d2_c[18:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            rev_reg    <= rev_c;
            bypass_reg <= bypass_c;
            hold_reg   <= hold_c;
            d2mag_reg  <= d2_abs;
            d2neg_reg  <= d2_c[19] ^ inv_c;
            d2zero_reg <= (d2_c == 20'sd0);
            old_reg    <= old_sel;
        end
        if (cmd.mul1) begin
            num_reg <= {6'b0, d2mag_reg} * {19'b0, cfg.step_count};
        end
        if (cmd.mul2) begin
            numx_reg <= {15'b0, num_reg} * 40'(ROUND_SCALE)
                      + {24'b0, cfg.regulation_range, 1'b0};
            denx_reg <= {14'b0, cfg.regulation_range, 1'b0} * 30'(ROUND_SCALE);
        end
    end

    // Divider operand selection: step move first, then old ratio, then new ratio
    always_comb begin
        special    = (cfg.step_count == 6'd0) || (cfg.regulation_range == 15'd0);
        ratio_step = cmd.take_move ? old_reg : step_new_reg;
        rs_abs     = ratio_step[6] ? 6'(-ratio_step) : ratio_step[5:0];
        rmag       = {15'b0, rs_abs} * {6'b0, cfg.regulation_range};
        rdividend  = {1'b0, rmag, 1'b0} + {17'b0, cfg.step_count};
        div_start  = cmd.div_move || cmd.take_move || cmd.take_old;
        if (cmd.div_move) begin
            div_dividend = numx_reg;
            div_divisor  = DIV_DEN_W'(denx_reg) << MOVE_QBITS;
            div_steps    = DIV_CNT_W'(MOVE_QBITS + 1);
        end else begin
            div_dividend = DIV_NUM_W'(rdividend);
            div_divisor  = DIV_DEN_W'({cfg.step_count, 1'b0}) << RATIO_QBITS;
            div_steps    = DIV_CNT_W'(RATIO_QBITS + 1);
        end
    end

    rtsc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .quotient (div_q),
        .done     (div_done)
    );

    assign stat.div_done = div_done;

    // New step: old step plus discretised move, clamped; zero in bypass, old step in band
    always_comb begin
        mv_mag = div_q[MOVE_QBITS] ? 8'd128 : {1'b0, div_q[MOVE_QBITS-1:0]} + 8'd1;
        if (d2zero_reg || cfg.step_count == 6'd0) begin
            mv_sel = 8'd0;
        end else if (cfg.regulation_range == 15'd0) begin
            mv_sel = 8'd127;
        end else begin
            mv_sel = mv_mag;
        end
        mv_s    = d2neg_reg ? -signed'({2'b0, mv_sel}) : signed'({2'b0, mv_sel});
        sum_c   = {{3{old_reg[6]}}, old_reg} + mv_s;
        lim     = (cfg.step_count > LIM_CAP) ? LIM_CAP : cfg.step_count;
        lim_s   = signed'({4'b0, lim});
        if (sum_c > lim_s) begin
            clamp_c = lim_s;
        end else if (sum_c < -lim_s) begin
            clamp_c = -lim_s;
        end else begin
            clamp_c = sum_c;
        end
        if (bypass_reg) begin
            step_c = '0;
        end else if (hold_reg) begin
            step_c = old_reg;
        end else begin
            step_c = clamp_c[6:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_move) begin
            step_new_reg <= step_c;
        end
        if (cmd.take_old) begin
            ratio_old_reg <= ratio_of(div_q, old_reg[6], special);
        end
        if (cmd.take_new) begin
            ratio_new_reg <= ratio_of(div_q, step_new_reg[6], special);
        end
        if (cmd.out_load) begin
            out_step_reg  <= step_new_reg;
            out_ratio_reg <= ratio_new_reg;
            out_rev_reg   <= rev_reg;
            out_chg_reg   <= ratio_new_reg != ratio_old_reg;
        end
    end

    assign m_tap_step     = out_step_reg;
    assign m_tap_ratio    = out_ratio_reg;
    assign m_flow_reverse = out_rev_reg;
    assign m_tap_changed  = out_chg_reg;

endmodule

>>> rtl/rtsc_ctrl.sv
module rtsc_ctrl
    import rtsc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_PREP  = 9'b000000010,
        ST_MUL1  = 9'b000000100,
        ST_MUL2  = 9'b000001000,
        ST_DIVM  = 9'b000010000,
        ST_WAITM = 9'b000100000,
        ST_WAITO = 9'b001000000,
        ST_WAITN = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_DIVM;
            end
            ST_DIVM: begin
                cmd.div_move = 1'b1;
                state_next   = ST_WAITM;
            end
            ST_WAITM: begin
                if (stat.div_done) begin
                    cmd.take_move = 1'b1;
                    state_next    = ST_WAITO;
                end
            end
            ST_WAITO: begin
                if (stat.div_done) begin
                    cmd.take_old = 1'b1;
                    state_next   = ST_WAITN;
                end
            end
            ST_WAITN: begin
                if (stat.div_done) begin
                    cmd.take_new = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

>>> rtl/regulator_tap_step_control.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_tap_index, s_measured_voltage, s_active_power_w
// m_        out        m_valid / m_ready  m_tap_step, m_tap_ratio, m_flow_reverse, m_tap_changed
// cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// One item is in work at a time: the next input transfer is taken only once
// the result is in the output register and the sequencer is back in idle.
// The shared serial divider makes three passes: the step move, then the old
// and then the new tap ratio.
// Reset (aresetn low, synchronous) loads register defaults and neutral steps.
// A stalled result sits in the output register while the next item is taken.
module regulator_tap_step_control
    import rtsc_pkg::*;
#(
    parameter int NUM_TAPS = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input item channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_tap_index,
    input  logic [16:0]           s_measured_voltage,
    input  logic signed [31:0]    s_active_power_w,
    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [6:0]     m_tap_step,
    output logic [16:0]           m_tap_ratio,
    output logic                  m_flow_reverse,
    output logic                  m_tap_changed,
    // Register write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Register file: take writes at any time; the user must keep them between items
    rtsc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Sequencer: walk prep, two multiplier stages, then three divider passes
    rtsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: direction and band decision, step store, divider, output register
    rtsc_dp #(
        .NUM_TAPS (NUM_TAPS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg),
        .cmd                (cmd),
        .stat               (stat),
        .s_tap_index        (s_tap_index),
        .s_measured_voltage (s_measured_voltage),
        .s_active_power_w   (s_active_power_w),
        .m_tap_step         (m_tap_step),
        .m_tap_ratio        (m_tap_ratio),
        .m_flow_reverse     (m_flow_reverse),
        .m_tap_changed      (m_tap_changed)
    );

endmodule

>>> bench/regulator_tap_step_control_tb.sv
`timescale 1ns / 1ps

module regulator_tap_step_control_tb;
    import rtsc_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 5;
    localparam int CYCLE_LIMIT   = 1000000;
    // Leave a margin after the last result before touching registers.
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 110;
    // Long receiver hold-off: starts once this many items were taken in.
    localparam int HOLD_AT       = 300;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic               tap;
        logic [16:0]        volts;
        logic signed [31:0] power;
    } tap_item_t;

    typedef struct {
        logic signed [6:0] step;
        logic [16:0]       ratio;
        logic              flow_rev;
        logic              changed;
    } tap_result_t;

    // DUT ports
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_tap_index = 1'b0;
    logic [16:0]           s_measured_voltage = '0;
    logic signed [31:0]    s_active_power_w = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic signed [6:0]     m_tap_step;
    logic [16:0]           m_tap_ratio;
    logic                  m_flow_reverse;
    logic                  m_tap_changed;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Mirror of the register file and of the per-tap step store
    cfg_t   ctl_regs;
    longint tap_steps [2];

    tap_item_t   pending_items [$];
    tap_result_t expected_results [$];

    int items_queued   = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // Idling knobs, set per phase by the stimulus process
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    bit          calm      = 1'b0;

    logic in_taken = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;

    regulator_tap_step_control #(
        .NUM_TAPS(2)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_tap_index       (s_tap_index),
        .s_measured_voltage(s_measured_voltage),
        .s_active_power_w  (s_active_power_w),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_tap_step        (m_tap_step),
        .m_tap_ratio       (m_tap_ratio),
        .m_flow_reverse    (m_flow_reverse),
        .m_tap_changed     (m_tap_changed),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Tap controller prediction
    // ------------------------------------------------------------------

    // Ratio in Q16 for a given step: 1 + step * range / step_count, rounded
    // half away from zero and saturated to the 17-bit range.
    function automatic logic [16:0] ratio_for_step(input longint stp);
        longint sc, rng, mag, q, r;
        sc  = longint'(ctl_regs.step_count);
        rng = longint'(ctl_regs.regulation_range);
        if (sc == 0 || rng == 0) begin
            return RATIO_ONE;
        end
        mag = (stp < 0 ? -stp : stp) * rng;
        q   = (2 * mag + sc) / (2 * sc);
        r   = (stp < 0) ? 65536 - q : 65536 + q;
        if (r < 0) r = 0;
        if (r > 131071) r = 131071;
        return r[16:0];
    endfunction

    // Discrete move for a doubled distance to the band edge: floor of the
    // scaled distance plus the 0.0001 bias, plus one step, signed.
    function automatic longint tap_move(input longint d2);
        longint sc, rng, num, den, fl;
        sc  = longint'(ctl_regs.step_count);
        rng = longint'(ctl_regs.regulation_range);
        if (d2 == 0 || sc == 0) begin
            return 0;
        end
        if (rng == 0) begin
            return (d2 > 0) ? 127 : -127;
        end
        num = (d2 < 0 ? -d2 : d2) * sc;
        den = 2 * rng;
        fl  = (num * 10000 + den) / (den * 10000);
        return (d2 > 0) ? fl + 1 : -fl - 1;
    endfunction

    // Work out the result of one item and advance the step store.
    function automatic tap_result_t predict_tap_result(input logic tap,
                                                       input logic [16:0] volts,
                                                       input logic signed [31:0] power);
        tap_result_t res;
        longint      v, pw, lim, old, stp, target, band, diff2, d2;
        logic        rev;
        v   = longint'(volts);
        pw  = longint'(power);
        rev = ctl_regs.two_way_mode && (pw <= -100);
        lim = longint'(ctl_regs.step_count);
        if (lim > MAX_STEPS) lim = MAX_STEPS;
        if (lim > 63) lim = 63;
        old = tap_steps[tap];

        if (rev && ctl_regs.reverse_submode == REV_BYPASS) begin
            stp = 0;
        end else begin
            target = rev ? longint'(ctl_regs.ref_voltage_rev) : longint'(ctl_regs.ref_voltage_fwd);
            band   = rev ? longint'(ctl_regs.band_rev) : longint'(ctl_regs.band_fwd);
            diff2  = 2 * (target - v);
            if ((diff2 < 0 ? -diff2 : diff2) < band) begin
                // inside half the dead band: hold the step
                stp = old;
            end else begin
                d2 = (v < target) ? diff2 - band : diff2 + band;
                // reverse flow flips the correction except in the fixed submode
                if (rev && ctl_regs.reverse_submode != REV_FIXED) d2 = -d2;
                stp = old + tap_move(d2);
                if (stp > lim) stp = lim;
                else if (stp < -lim) stp = -lim;
            end
        end

        res.step     = stp[6:0];
        res.ratio    = ratio_for_step(stp);
        res.flow_rev = rev;
        res.changed  = (res.ratio != ratio_for_step(old));
        tap_steps[tap] = stp;
        return res;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_TWO_WAY_MODE:     ctl_regs.two_way_mode     = val[0];
            CFG_REVERSE_SUBMODE:  ctl_regs.reverse_submode  = val[1:0];
            CFG_REF_VOLTAGE_FWD:  ctl_regs.ref_voltage_fwd  = val[16:0];
            CFG_REF_VOLTAGE_REV:  ctl_regs.ref_voltage_rev  = val[16:0];
            CFG_BAND_FWD:         ctl_regs.band_fwd         = val[14:0];
            CFG_BAND_REV:         ctl_regs.band_rev         = val[14:0];
            CFG_REGULATION_RANGE: ctl_regs.regulation_range = val[14:0];
            CFG_STEP_COUNT:       ctl_regs.step_count       = val[5:0];
            default: ;
        endcase
    endfunction

    // Either an extreme of the register or a value from the typical window.
    function automatic logic [16:0] pick_setting(input int unsigned min_v,
                                                 input int unsigned max_v,
                                                 input int unsigned lo,
                                                 input int unsigned hi);
        case ($urandom_range(0, 5))
            0:       return 17'(min_v);
            1:       return 17'(max_v);
            default: return 17'($urandom_range(lo, hi));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Drive one register write; only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        apply_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_item(input logic tap, input logic [16:0] volts,
                              input logic signed [31:0] power);
        tap_item_t it;
        it.tap   = tap;
        it.volts = volts;
        it.power = power;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Wait for every queued item to come back, then let the block settle.
    task automatic wait_idle();
        while (results_seen != items_queued) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic note_mismatch(input string why, input tap_result_t want,
                                 input tap_result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t %s: got/exp step %0d/%0d ratio %0d/%0d rev %0b/%0b chg %0b/%0b",
                     $time, why, got.step, want.step, got.ratio, want.ratio,
                     got.flow_rev, want.flow_rev, got.changed, want.changed);
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: present items from the pending queue at the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        tap_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // hold the offered item until the block takes it
        end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            s_valid  <= 1'b0;
        end else if (pending_items.size() == 0) begin
            s_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
            // start an idle burst that includes this cycle
            gap_left <= $urandom_range(0, 18);
            s_valid  <= 1'b0;
        end else begin
            it = pending_items.pop_front();
            s_valid            <= 1'b1;
            s_tap_index        <= it.tap;
            s_measured_voltage <= it.volts;
            s_active_power_w   <= it.power;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stall bursts plus one long hold-off that lets
    // the block fill up and drop s_ready while the driver keeps offering.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && items_accepted >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD - 1;
            m_ready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 18);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result transfer against the oldest expectation,
    // then predict the result of any input transfer in the same cycle.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        tap_result_t want;
        tap_result_t got;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                got.step     = m_tap_step;
                got.ratio    = m_tap_ratio;
                got.flow_rev = m_flow_reverse;
                got.changed  = m_tap_changed;
                if (expected_results.size() == 0) begin
                    want = '{default: '0};
                    note_mismatch("result with nothing expected", want, got);
                end else begin
                    want = expected_results.pop_front();
                    results_seen <= results_seen + 1;
                    if (got.step !== want.step || got.ratio !== want.ratio ||
                        got.flow_rev !== want.flow_rev || got.changed !== want.changed) begin
                        note_mismatch("field differs", want, got);
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_tap_result(s_tap_index,
                                                              s_measured_voltage,
                                                              s_active_power_w));
                items_accepted <= items_accepted + 1;
            end
        end
    end

    // Watchdog: end the run if the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL regulator_tap_step_control");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        int                 reach, off, vv, band_max;
        longint             target;
        logic               tap;
        logic signed [31:0] pw;

        ctl_regs.two_way_mode     = 1'b0;
        ctl_regs.reverse_submode  = REV_INVERT;
        ctl_regs.ref_voltage_fwd  = RATIO_ONE;
        ctl_regs.ref_voltage_rev  = RATIO_ONE;
        ctl_regs.band_fwd         = '0;
        ctl_regs.band_rev         = '0;
        ctl_regs.regulation_range = 15'd6554;
        ctl_regs.step_count       = 6'd16;
        tap_steps[0] = 0;
        tap_steps[1] = 0;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        gap_pct   = 20;
        stall_pct = 20;

        // Reset settings: forward only, zero band, 16 steps.
        queue_item(1'b0, 17'd0, 32'sd0);                 // far low, clamp up
        queue_item(1'b0, 17'd131071, 32'sh7FFFFFFF);     // far high, clamp down
        queue_item(1'b1, 17'd65536, 32'sh80000000);      // on reference, no move; power ignored
        queue_item(1'b1, 17'd65540, -32'sd1);
        queue_item(1'b1, 17'd65530, 32'sd1);
        wait_idle();

        // Two-way with inverted reverse correction; power threshold at -100 W.
        write_reg(CFG_TWO_WAY_MODE, 17'd1);
        write_reg(CFG_REVERSE_SUBMODE, 17'(REV_INVERT));
        write_reg(CFG_REF_VOLTAGE_FWD, 17'd65536);
        write_reg(CFG_REF_VOLTAGE_REV, 17'd62000);
        write_reg(CFG_BAND_FWD, 17'd1310);
        write_reg(CFG_BAND_REV, 17'd2000);
        write_reg(CFG_REGULATION_RANGE, 17'd6554);
        write_reg(CFG_STEP_COUNT, 17'd16);
        queue_item(1'b0, 17'd65536, -32'sd99);           // forward, inside band
        queue_item(1'b0, 17'd66300, -32'sd100);          // just reverse
        queue_item(1'b1, 17'd61000, 32'sh80000000);      // most negative power
        queue_item(1'b0, 17'd66191, 32'sd100);           // exactly on the band edge
        queue_item(1'b1, 17'd70000, 32'sh7FFFFFFF);
        wait_idle();

        // Bypass on reverse flow
        write_reg(CFG_REVERSE_SUBMODE, 17'(REV_BYPASS));
        queue_item(1'b0, 17'd50000, -32'sd5000);
        queue_item(1'b0, 17'd50000, 32'sd5000);
        wait_idle();

        // Fixed submode: reverse flow keeps the sign of the correction
        write_reg(CFG_REVERSE_SUBMODE, 17'(REV_FIXED));
        queue_item(1'b1, 17'd60000, -32'sd100000);
        queue_item(1'b1, 17'd70000, -32'sd100000);
        wait_idle();

        // Register extremes: tightest range, most steps, widest band
        write_reg(CFG_REVERSE_SUBMODE, 17'(REV_INVERT));
        write_reg(CFG_REF_VOLTAGE_FWD, 17'd0);
        write_reg(CFG_REF_VOLTAGE_REV, 17'd131071);
        write_reg(CFG_BAND_FWD, 17'd32767);
        write_reg(CFG_BAND_REV, 17'd0);
        write_reg(CFG_REGULATION_RANGE, 17'd1);
        write_reg(CFG_STEP_COUNT, 17'd32);
        queue_item(1'b0, 17'd0, 32'sd0);
        queue_item(1'b0, 17'd131071, 32'sd0);
        queue_item(1'b1, 17'd131071, 32'sh80000000);
        queue_item(1'b1, 17'd0, -32'sd200);
        wait_idle();

        // Widest range, single step
        write_reg(CFG_REGULATION_RANGE, 17'd32767);
        write_reg(CFG_STEP_COUNT, 17'd1);
        queue_item(1'b0, 17'd20000, 32'sd1);
        queue_item(1'b1, 17'd100000, -32'sd1000);
        wait_idle();

        // Random phases, each with fresh registers and idling mix
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_reg(CFG_TWO_WAY_MODE, 17'($urandom_range(0, 3) != 0));
            write_reg(CFG_REVERSE_SUBMODE, 17'($urandom_range(REV_INVERT, REV_FIXED)));
            write_reg(CFG_REF_VOLTAGE_FWD, pick_setting(0, 131071, 57536, 73536));
            write_reg(CFG_REF_VOLTAGE_REV, pick_setting(0, 131071, 57536, 73536));
            write_reg(CFG_BAND_FWD, pick_setting(0, 32767, 0, 4000));
            write_reg(CFG_BAND_REV, pick_setting(0, 32767, 0, 4000));
            write_reg(CFG_REGULATION_RANGE, pick_setting(1, 32767, 600, 20000));
            write_reg(CFG_STEP_COUNT, pick_setting(1, 32, 1, 32));

            // no idling in the closing phase; some phases run without it too
            calm      = (phase == RANDOM_PHASES - 1);
            gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);

            band_max = (ctl_regs.band_fwd > ctl_regs.band_rev) ?
                       int'(ctl_regs.band_fwd) : int'(ctl_regs.band_rev);
            reach = band_max + int'(ctl_regs.regulation_range) * 4 / int'(ctl_regs.step_count) + 64;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                tap = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 3))
                    0:       pw = $urandom;
                    1:       pw = -int'($urandom_range(100, 2000000));
                    2:       pw = int'($urandom_range(0, 2000000));
                    default: pw = -98 - int'($urandom_range(0, 4));
                endcase
                if ($urandom_range(0, 7) == 0) begin
                    // noise: anywhere in the voltage range
                    vv = $urandom_range(0, 131071);
                end else begin
                    // mostly around one of the references so the band logic works
                    target = $urandom_range(0, 1) ? longint'(ctl_regs.ref_voltage_rev) :
                                                    longint'(ctl_regs.ref_voltage_fwd);
                    off = int'($urandom_range(0, 2 * reach)) - reach;
                    vv  = int'(target) + off;
                    if (vv < 0) vv = 0;
                    if (vv > 131071) vv = 131071;
                end
                queue_item(tap, vv[16:0], pw);
            end
            wait_idle();
        end

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASS regulator_tap_step_control");
        end else begin
            $display("FAIL regulator_tap_step_control");
        end
        $finish;
    end

endmodule
